FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property holds at every clock edge outside reset
`define ASSERT_AT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: hw/rtl/hsvrgb_pkg.sv
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// types, constants and helpers of the hsv to rgb converter
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

    // hue sector, 0..5 are colors, 6..8 come from hues of 360 and above
    typedef logic [3:0] sector_t;
    typedef logic [7:0] level_t;
    typedef logic [15:0] prod_t;

    localparam int HueWidth     = 9;
    localparam int SectorSpan   = 60;
    localparam int SectorLimit  = 8;
    localparam level_t FullLevel = 8'hFF;
    localparam level_t AlphaLevel = 8'hFF;

    // color sectors of the hue circle
    localparam sector_t SecRedYellow    = 4'd0;
    localparam sector_t SecYellowGreen  = 4'd1;
    localparam sector_t SecGreenCyan    = 4'd2;
    localparam sector_t SecCyanBlue     = 4'd3;
    localparam sector_t SecBlueMagenta  = 4'd4;
    localparam sector_t SecMagentaRed   = 4'd5;

    // floor(x / 255), exact for every product of two 8-bit levels
    function automatic level_t div255(input prod_t x);
        prod_t sum;
        sum = x + {8'd0, x[15:8]} + 16'd1;
        return sum[15:8];
    endfunction

endpackage

FILE: hw/rtl/hsv_to_rgb_converter_core.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_core
// five-stage pipelined integer hsv to packed argb pixel converter
// ----------------------------------------------------------------------------
// path: an input beat passes stages 1 to 5 in order and leaves stage 5 as the result beat
// throughput: one beat per cycle while m_tready is high, less while the output stalls
// each stage holds its own valid bit and fills bubbles while the output stalls
// reset: aresetn clears all stage valid bits, payload registers are not reset
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hsv_to_rgb_converter_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // hue[8:0], saturation[16:9], brightness[24:17], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // argb_word[31:0]
);

    // input fields
    logic [hsvrgb_pkg::HueWidth-1:0] in_hue;
    hsvrgb_pkg::level_t in_sat;
    hsvrgb_pkg::level_t in_val;

    assign in_hue = s_tdata[8:0];
    assign in_sat = s_tdata[16:9];
    assign in_val = s_tdata[24:17];

    // stage valid bits and ready chain
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    assign rdy5 = !v5_reg || m_tready;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign s_tready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // stage 1: sector by threshold compares, scaled remainder
    hsvrgb_pkg::sector_t sector_next;
    logic [hsvrgb_pkg::HueWidth-1:0] base_next;
    logic [hsvrgb_pkg::HueWidth-1:0] rem_wide;
    logic [5:0] rem;
    logic [9:0] rem_x17;
    hsvrgb_pkg::level_t frac_next;

    always_comb begin
        sector_next = '0;
        base_next   = '0;
        for (int k = 1; k <= hsvrgb_pkg::SectorLimit; k++) begin
            if (in_hue >= 9'(k * hsvrgb_pkg::SectorSpan)) begin
                sector_next = 4'(k);
                base_next   = 9'(k * hsvrgb_pkg::SectorSpan);
            end
        end
        rem_wide = in_hue - base_next;
        rem      = rem_wide[5:0];
        // rem * 255 / 60 equals rem * 17 / 4
        rem_x17   = {rem, 4'd0} + {4'd0, rem};
        frac_next = rem_x17[9:2];
    end

    hsvrgb_pkg::sector_t sector1_reg;
    hsvrgb_pkg::level_t  frac1_reg, sat1_reg, val1_reg;

    always_ff @(posedge aclk) begin
        if (rdy1 && s_tvalid) begin
            sector1_reg <= sector_next;
            frac1_reg   <= frac_next;
            sat1_reg    <= in_sat;
            val1_reg    <= in_val;
        end
    end

    // stage 2: first products
    hsvrgb_pkg::sector_t sector2_reg;
    hsvrgb_pkg::level_t  val2_reg;
    hsvrgb_pkg::prod_t   sf2_reg, st2_reg, vp2_reg;

    always_ff @(posedge aclk) begin
        if (rdy2 && v1_reg) begin
            sector2_reg <= sector1_reg;
            val2_reg    <= val1_reg;
            sf2_reg     <= sat1_reg * frac1_reg;
            st2_reg     <= sat1_reg * (hsvrgb_pkg::FullLevel - frac1_reg);
            vp2_reg     <= val1_reg * (hsvrgb_pkg::FullLevel - sat1_reg);
        end
    end

    // stage 3: first divides by 255
    hsvrgb_pkg::sector_t sector3_reg;
    hsvrgb_pkg::level_t  val3_reg, qf3_reg, tf3_reg, p3_reg;

    always_ff @(posedge aclk) begin
        if (rdy3 && v2_reg) begin
            sector3_reg <= sector2_reg;
            val3_reg    <= val2_reg;
            qf3_reg     <= hsvrgb_pkg::FullLevel - hsvrgb_pkg::div255(sf2_reg);
            tf3_reg     <= hsvrgb_pkg::FullLevel - hsvrgb_pkg::div255(st2_reg);
            p3_reg      <= hsvrgb_pkg::div255(vp2_reg);
        end
    end

    // stage 4: second products
    hsvrgb_pkg::sector_t sector4_reg;
    hsvrgb_pkg::level_t  val4_reg, p4_reg;
    hsvrgb_pkg::prod_t   vq4_reg, vt4_reg;

    always_ff @(posedge aclk) begin
        if (rdy4 && v3_reg) begin
            sector4_reg <= sector3_reg;
            val4_reg    <= val3_reg;
            p4_reg      <= p3_reg;
            vq4_reg     <= val3_reg * qf3_reg;
            vt4_reg     <= val3_reg * tf3_reg;
        end
    end

    // stage 5: second divides and channel select
    hsvrgb_pkg::level_t lvl_q, lvl_t;
    hsvrgb_pkg::level_t red_next, green_next, blue_next;

    always_comb begin
        lvl_q      = hsvrgb_pkg::div255(vq4_reg);
        lvl_t      = hsvrgb_pkg::div255(vt4_reg);
        red_next   = '0;
        green_next = '0;
        blue_next  = '0;
        case (sector4_reg)
            hsvrgb_pkg::SecRedYellow: begin
                red_next = val4_reg; green_next = lvl_t; blue_next = p4_reg;
            end
            hsvrgb_pkg::SecYellowGreen: begin
                red_next = lvl_q; green_next = val4_reg; blue_next = p4_reg;
            end
            hsvrgb_pkg::SecGreenCyan: begin
                red_next = p4_reg; green_next = val4_reg; blue_next = lvl_t;
            end
            hsvrgb_pkg::SecCyanBlue: begin
                red_next = p4_reg; green_next = lvl_q; blue_next = val4_reg;
            end
            hsvrgb_pkg::SecBlueMagenta: begin
                red_next = lvl_t; green_next = p4_reg; blue_next = val4_reg;
            end
            hsvrgb_pkg::SecMagentaRed: begin
                red_next = val4_reg; green_next = p4_reg; blue_next = lvl_q;
            end
            default: begin
                // hues of 360 and above give black
                red_next = '0; green_next = '0; blue_next = '0;
            end
        endcase
    end

    hsvrgb_pkg::level_t red5_reg, green5_reg, blue5_reg;

    always_ff @(posedge aclk) begin
        if (rdy5 && v4_reg) begin
            red5_reg   <= red_next;
            green5_reg <= green_next;
            blue5_reg  <= blue_next;
        end
    end

    // output beat
    assign m_tvalid = v5_reg;
    assign m_tdata  = {hsvrgb_pkg::AlphaLevel, red5_reg, green5_reg, blue5_reg};

    // checks
    `ASSERT_AT(a_ready_when_out_empty, aclk, aresetn, !m_tvalid |-> s_tready)
    `ASSERT_AT(a_sector_range, aclk, aresetn, v1_reg |-> (sector1_reg <= 4'd8))
    `ASSERT_AT(a_frac_range, aclk, aresetn, v1_reg |-> (frac1_reg <= 8'd250))
    `ASSERT_NEXT(a_beat_reaches_stage1, aclk, aresetn, s_tvalid && s_tready, v1_reg)
    `ASSERT_NEXT(a_stall_keeps_out, aclk, aresetn, v4_reg && m_tvalid && !m_tready, v5_reg && v4_reg)

endmodule
